>>> sv/bhd_pkg.sv
// Shared constants, codes and controller/datapath command types for the hash dictionary.
package bhd_pkg;

    // Field widths
    localparam int CMD_W    = 2;
    localparam int KEY_W    = 32;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int TOTAL_W  = 7;

    // Table geometry
    localparam int NUM_BUCKETS  = 10;
    localparam int BUCKET_DEPTH = 8;
    localparam int STORE_SIZE   = NUM_BUCKETS * BUCKET_DEPTH;
    localparam int ADDR_W       = $clog2(STORE_SIZE);
    localparam int FILL_W       = $clog2(BUCKET_DEPTH + 1);
    localparam int REM_W        = $clog2(NUM_BUCKETS);

    // Bucket hash: remainder taken eight key bits per cycle
    localparam int HASH_BITS   = 8;
    localparam int HASH_CYCLES = KEY_W / HASH_BITS;
    localparam int HCNT_W      = $clog2(HASH_CYCLES);

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD     = 2'd0,
        CMD_RESOLVE = 2'd1,
        CMD_REMOVE  = 2'd2,
        CMD_CLEAR   = 2'd3
    } cmd_e_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_DUP     = 2'd1,
        ST_MISSING = 2'd2,
        ST_FULL    = 2'd3
    } status_e_t;

    // Controller to datapath
    typedef struct packed {
        logic      load;
        logic      hash;
        logic      scan_init;
        logic      scan_cmp;
        logic      add_wr;
        logic      shift_rd;
        logic      shift_wr;
        logic      remove_dec;
        logic      clear;
        logic      result;
        status_e_t res_status;
        logic      res_hit;
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic   hash_last;
        cmd_e_t cmd;
        logic   scan_end;
        logic   key_match;
        logic   found;
        logic   bucket_full;
        logic   shift_end;
    } dp_stat_t;

endpackage

>>> sv/bhd_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bhd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 80
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> sv/bhd_datapath.sv
// Datapath: bucket hash, pair stores, fill counts and the result word register.
module bhd_datapath import bhd_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [KEY_W-1:0]    s_key,
    input  logic [VALUE_W-1:0]  s_value,
    input  dp_cmd_t             ctl,
    output dp_stat_t            stat,
    output logic [STATUS_W-1:0] m_status,
    output logic [VALUE_W-1:0]  m_read_value,
    output logic [TOTAL_W-1:0]  m_total_pairs
);

    localparam logic [REM_W:0] NB_WIDE = (REM_W + 1)'(NUM_BUCKETS);

    cmd_e_t             cmd_reg;
    logic [KEY_W-1:0]   key_reg;
    logic [VALUE_W-1:0] value_reg;
    logic [KEY_W-1:0]   key_shift_reg;
    logic [REM_W-1:0]   rem_reg;
    logic [HCNT_W-1:0]  hcnt_reg;
    logic [FILL_W-1:0]  slot_reg;
    logic               found_reg;
    logic [VALUE_W-1:0] hit_value_reg;
    logic [FILL_W-1:0]  fill_reg [NUM_BUCKETS];
    logic [TOTAL_W-1:0] total_reg;
    status_e_t          out_status_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [TOTAL_W-1:0] out_total_reg;

    logic [REM_W-1:0]   rem_next;
    logic [REM_W:0]     rem_wide;
    logic [FILL_W-1:0]  fill_cur;
    logic [ADDR_W-1:0]  base_addr;
    logic [ADDR_W-1:0]  slot_addr;
    logic [ADDR_W-1:0]  ram_waddr;
    logic [ADDR_W-1:0]  ram_raddr;
    logic               ram_we;
    logic [KEY_W-1:0]   key_wdata;
    logic [VALUE_W-1:0] value_wdata;
    logic [KEY_W-1:0]   key_rdata;
    logic [VALUE_W-1:0] value_rdata;

    // Fold eight key bits into the running remainder, MSB first
    always_comb begin
        rem_next = rem_reg;
        rem_wide = '0;
        for (int i = 0; i < HASH_BITS; i++) begin
            rem_wide = {rem_next, key_shift_reg[KEY_W-1-i]};
            if (rem_wide >= NB_WIDE) begin
                rem_wide = rem_wide - NB_WIDE;
            end
            rem_next = rem_wide[REM_W-1:0];
        end
    end

    // Address the bucket's slots
    assign fill_cur  = fill_reg[rem_reg];
    assign base_addr = ADDR_W'(rem_reg) * ADDR_W'(BUCKET_DEPTH);
    assign slot_addr = base_addr + ADDR_W'(slot_reg);
    assign ram_raddr = ctl.shift_rd ? slot_addr + ADDR_W'(1) : slot_addr;
    assign ram_waddr = ctl.add_wr ? base_addr + ADDR_W'(fill_cur) : slot_addr;
    assign ram_we    = ctl.add_wr | ctl.shift_wr;
    assign key_wdata   = ctl.add_wr ? key_reg : key_rdata;
    assign value_wdata = ctl.add_wr ? value_reg : value_rdata;

    bhd_ram #(.WIDTH(KEY_W), .DEPTH(STORE_SIZE)) u_key_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (key_wdata),
        .raddr (ram_raddr),
        .rdata (key_rdata)
    );

    bhd_ram #(.WIDTH(VALUE_W), .DEPTH(STORE_SIZE)) u_value_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (value_wdata),
        .raddr (ram_raddr),
        .rdata (value_rdata)
    );

    // Report status to the controller
    assign stat.hash_last   = (hcnt_reg == HCNT_W'(HASH_CYCLES - 1));
    assign stat.cmd         = cmd_reg;
    assign stat.scan_end    = (slot_reg >= fill_cur);
    assign stat.key_match   = (key_rdata == key_reg);
    assign stat.found       = found_reg;
    assign stat.bucket_full = (fill_cur >= FILL_W'(BUCKET_DEPTH));
    assign stat.shift_end   = ((slot_reg + FILL_W'(1)) >= fill_cur);

    // Update fill counts and the pair total
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int b = 0; b < NUM_BUCKETS; b++) begin
                fill_reg[b] <= '0;
            end
            total_reg <= '0;
        end else begin
            if (ctl.clear) begin
                for (int b = 0; b < NUM_BUCKETS; b++) begin
                    fill_reg[b] <= '0;
                end
                total_reg <= '0;
            end
            if (ctl.add_wr) begin
                fill_reg[rem_reg] <= fill_cur + FILL_W'(1);
                total_reg         <= total_reg + TOTAL_W'(1);
            end
            if (ctl.remove_dec) begin
                fill_reg[rem_reg] <= fill_cur - FILL_W'(1);
                total_reg         <= total_reg - TOTAL_W'(1);
            end
        end
    end

    // Capture the word, hash, scan, shift and load the result word
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            cmd_reg       <= cmd_e_t'(s_cmd);
            key_reg       <= s_key;
            value_reg     <= s_value;
            key_shift_reg <= s_key;
            rem_reg       <= '0;
            hcnt_reg      <= '0;
        end
        if (ctl.hash) begin
            rem_reg       <= rem_next;
            key_shift_reg <= key_shift_reg << HASH_BITS;
            hcnt_reg      <= hcnt_reg + HCNT_W'(1);
        end
        if (ctl.scan_init) begin
            slot_reg  <= '0;
            found_reg <= 1'b0;
        end
        if (ctl.scan_cmp) begin
            if (stat.key_match) begin
                found_reg     <= 1'b1;
                hit_value_reg <= value_rdata;
            end else begin
                slot_reg <= slot_reg + FILL_W'(1);
            end
        end
        if (ctl.shift_wr) begin
            slot_reg <= slot_reg + FILL_W'(1);
        end
        if (ctl.result) begin
            out_status_reg <= ctl.res_status;
            out_value_reg  <= ctl.res_hit ? hit_value_reg : '0;
            out_total_reg  <= total_reg;
        end
    end

    assign m_status      = out_status_reg;
    assign m_read_value  = out_value_reg;
    assign m_total_pairs = out_total_reg;

endmodule

>>> sv/bhd_ctrl.sv
// Controller: sequences hash, bucket scan, insert or shift, and the result handshake.
module bhd_ctrl import bhd_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    output logic     m_valid,
    input  logic     m_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  ctl
);

    typedef enum logic [2:0] {
        IDLE,
        HASH,
        SCAN_RD,
        SCAN_CMP,
        DECIDE,
        SHIFT_RD,
        SHIFT_WR,
        FINISH
    } state_t;

    state_t    state_reg, state_next;
    logic      out_valid_reg, out_valid_next;
    status_e_t res_status_reg, res_status_next;
    logic      res_hit_reg, res_hit_next;

    // Next state and datapath commands
    always_comb begin
        ctl             = '0;
        state_next      = state_reg;
        out_valid_next  = out_valid_reg && !m_ready;
        res_status_next = res_status_reg;
        res_hit_next    = res_hit_reg;
        unique case (state_reg)
            IDLE: begin
                if (s_valid) begin
                    ctl.load   = 1'b1;
                    state_next = HASH;
                end
            end
            HASH: begin
                ctl.hash = 1'b1;
                if (stat.hash_last) begin
                    if (stat.cmd == CMD_CLEAR) begin
                        ctl.clear       = 1'b1;
                        res_status_next = ST_OK;
                        res_hit_next    = 1'b0;
                        state_next      = FINISH;
                    end else begin
                        ctl.scan_init = 1'b1;
                        state_next    = SCAN_RD;
                    end
                end
            end
            SCAN_RD: begin
                state_next = stat.scan_end ? DECIDE : SCAN_CMP;
            end
            SCAN_CMP: begin
                ctl.scan_cmp = 1'b1;
                state_next   = stat.key_match ? DECIDE : SCAN_RD;
            end
            DECIDE: begin
                res_hit_next = 1'b0;
                state_next   = FINISH;
                unique case (stat.cmd)
                    CMD_ADD: begin
                        if (stat.found) begin
                            res_status_next = ST_DUP;
                        end else if (stat.bucket_full) begin
                            res_status_next = ST_FULL;
                        end else begin
                            ctl.add_wr      = 1'b1;
                            res_status_next = ST_OK;
                        end
                    end
                    CMD_RESOLVE: begin
                        res_status_next = stat.found ? ST_OK : ST_MISSING;
                        res_hit_next    = stat.found;
                    end
                    CMD_REMOVE: begin
                        res_status_next = stat.found ? ST_OK : ST_MISSING;
                        if (stat.found) begin
                            state_next = SHIFT_RD;
                        end
                    end
                    CMD_CLEAR: begin
                        res_status_next = ST_OK;
                    end
                endcase
            end
            SHIFT_RD: begin
                if (stat.shift_end) begin
                    ctl.remove_dec = 1'b1;
                    state_next     = FINISH;
                end else begin
                    ctl.shift_rd = 1'b1;
                    state_next   = SHIFT_WR;
                end
            end
            SHIFT_WR: begin
                ctl.shift_wr = 1'b1;
                state_next   = SHIFT_RD;
            end
            FINISH: begin
                ctl.res_status = res_status_reg;
                ctl.res_hit    = res_hit_reg;
                if (!out_valid_reg || m_ready) begin
                    ctl.result     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = IDLE;
                end
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= IDLE;
            out_valid_reg  <= 1'b0;
            res_status_reg <= ST_OK;
            res_hit_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            res_status_reg <= res_status_next;
            res_hit_reg    <= res_hit_next;
        end
    end

    assign s_ready = (state_reg == IDLE);
    assign m_valid = out_valid_reg;

endmodule

>>> sv/bucketed_hash_dictionary.sv
// Top level of the bucketed hash dictionary: controller, datapath and checks.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+----------------------------------------
//  s_       | in        | s_valid / s_ready  | s_cmd[1:0], s_key[31:0], s_value[31:0]
//  m_       | out       | m_valid / m_ready  | m_status[1:0], m_read_value[31:0],
//           |           |                    | m_total_pairs[6:0]
//
// One word is in work at a time. The bucket index is reckoned eight key bits a cycle
// through the modulo step; the scan of the bucket reads and compares one pair at a
// time, and a remove then moves each later pair down one slot with a read and a
// write, both bound by the single read port of the pair RAMs. Clear goes from the
// hash straight to the result, with no scan. Reset is synchronous and active low
// and empties every bucket at once. A stalled result word holds in the output
// register while the next input word is already taken in.
module bucketed_hash_dictionary import bhd_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [CMD_W-1:0]    s_cmd,
    input  logic [KEY_W-1:0]    s_key,
    input  logic [VALUE_W-1:0]  s_value,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [STATUS_W-1:0] m_status,
    output logic [VALUE_W-1:0]  m_read_value,
    output logic [TOTAL_W-1:0]  m_total_pairs
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    bhd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (dp_stat),
        .ctl     (dp_cmd)
    );

    bhd_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_cmd         (s_cmd),
        .s_key         (s_key),
        .s_value       (s_value),
        .ctl           (dp_cmd),
        .stat          (dp_stat),
        .m_status      (m_status),
        .m_read_value  (m_read_value),
        .m_total_pairs (m_total_pairs)
    );

    // s_ready falls after a word is accepted
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken while a word is in work");

    // Only a successful lookup returns a nonzero value
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_read_value != '0)) |-> (m_status == ST_OK))
        else $error("value returned with an error status");

    // Never append a duplicate key or into a full bucket
    assert property (@(posedge aclk) disable iff (!aresetn)
        dp_cmd.add_wr |-> (!dp_stat.found && !dp_stat.bucket_full))
        else $error("append with duplicate key or full bucket");

    // At most one of append, shift write and clear per cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({dp_cmd.add_wr, dp_cmd.shift_wr, dp_cmd.clear}))
        else $error("conflicting store updates");

endmodule
